// ===== hw/rtl/scheduled_multichannel_pwm_defines.svh =====
// Assertion macros for the scheduled multichannel PWM block.
// Included by the top level; no other dependencies.
`ifndef SCHEDULED_MULTICHANNEL_PWM_DEFINES_SVH
`define SCHEDULED_MULTICHANNEL_PWM_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define SMPWM_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error("smpwm assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define SMPWM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error("smpwm assertion failed");
`else
`define SMPWM_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define SMPWM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== hw/rtl/smpwm_pkg.sv =====
// Shared constants, status codes and controller/datapath interface types
// for the scheduled multichannel PWM block. No dependencies.
package smpwm_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int PERIOD_US   = 10000;
    localparam int DUTY_STEP   = PERIOD_US / 100;

    localparam int PIN_LIMIT  = 20;
    localparam int DUTY_LIMIT = 100;
    localparam int TIME_LIMIT = 2400;
    localparam int PIN_COUNT  = PIN_LIMIT + 1;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int THR_W = $clog2(DUTY_LIMIT * DUTY_STEP + 1);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic             load;
        logic             cfg_en;
        logic             walk_en;
        logic [IDX_W-1:0] walk_idx;
        logic             out_load;
    } smpwm_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic             count_full;
    } smpwm_sts_t;

endpackage

// ===== hw/rtl/smpwm_dp.sv =====
// Datapath of the scheduled multichannel PWM block: input capture, entry
// table, per-entry window and duty evaluation, pin state and result register.
// Depends on smpwm_pkg.
module smpwm_dp
    import smpwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  smpwm_cmd_t           cmd,
    output smpwm_sts_t           sts,
    input  logic [7:0]           pin_number,
    input  logic [7:0]           duty_percent,
    input  logic [15:0]          window_start,
    input  logic [15:0]          window_end,
    input  logic [15:0]          time_of_day,
    input  logic [31:0]          now_us,
    output logic [1:0]           status,
    output logic [PIN_COUNT-1:0] pin_levels
);

    // Captured item fields.
    logic [7:0]  pin_in_reg;
    logic [7:0]  duty_in_reg;
    logic [15:0] wstart_reg;
    logic [15:0] wend_reg;
    logic [15:0] tod_reg;
    logic [31:0] now_reg;

    // Entry table.
    logic [4:0]  entry_pin_reg   [MAX_ENTRIES];
    logic [6:0]  entry_duty_reg  [MAX_ENTRIES];
    logic [11:0] entry_open_reg  [MAX_ENTRIES];
    logic [11:0] entry_close_reg [MAX_ENTRIES];
    logic        entry_night_reg [MAX_ENTRIES];
    logic [31:0] entry_start_reg [MAX_ENTRIES];

    logic [CNT_W-1:0]     entry_count_reg;
    logic [CNT_W-1:0]     entry_count_next;
    logic [PIN_COUNT-1:0] pin_state_reg;
    logic [PIN_COUNT-1:0] pin_state_next;
    logic [1:0]           stat_reg;
    logic [1:0]           stat_next;
    logic [1:0]           status_reg;
    logic [PIN_COUNT-1:0] pin_levels_reg;

    logic                 cfg_valid;
    logic                 cfg_store;
    logic [IDX_W-1:0]     wr_idx;

    logic [4:0]           e_pin;
    logic [6:0]           e_duty;
    logic [11:0]          e_open;
    logic [11:0]          e_close;
    logic                 e_night;
    logic [31:0]          e_start;
    logic [31:0]          elapsed;
    logic [THR_W-1:0]     duty_thr;
    logic [PIN_COUNT-1:0] pin_mask;
    logic                 in_window;
    logic                 set_start;
    logic                 set_night;
    logic                 clr_night;

    assign sts.entry_count = entry_count_reg;
    assign sts.count_full  = (entry_count_reg >= CNT_W'(MAX_ENTRIES));

    assign cfg_valid = (pin_in_reg <= 8'(PIN_LIMIT)) && (duty_in_reg <= 8'(DUTY_LIMIT))
                    && (wstart_reg <= 16'(TIME_LIMIT)) && (wend_reg <= 16'(TIME_LIMIT))
                    && (wend_reg > wstart_reg);
    assign cfg_store = cmd.cfg_en && cfg_valid && !sts.count_full;
    assign wr_idx    = entry_count_reg[IDX_W-1:0];

    assign e_pin    = entry_pin_reg[cmd.walk_idx];
    assign e_duty   = entry_duty_reg[cmd.walk_idx];
    assign e_open   = entry_open_reg[cmd.walk_idx];
    assign e_close  = entry_close_reg[cmd.walk_idx];
    assign e_night  = entry_night_reg[cmd.walk_idx];
    assign e_start  = entry_start_reg[cmd.walk_idx];
    assign elapsed  = now_reg - e_start;
    assign duty_thr = THR_W'(e_duty) * THR_W'(DUTY_STEP);
    // Pins above the limit shift out of the vector and leave it untouched.
    assign pin_mask = PIN_COUNT'(1) << e_pin;
    assign in_window = (tod_reg >= 16'(e_open)) && (tod_reg < 16'(e_close));

    always_comb
    begin
        pin_state_next   = pin_state_reg;
        entry_count_next = entry_count_reg;
        stat_next        = stat_reg;
        set_start        = 1'b0;
        set_night        = 1'b0;
        clr_night        = 1'b0;
        if (cmd.load)
        begin
            stat_next = ST_OK;
        end
        if (cmd.cfg_en)
        begin
            if (!cfg_valid)
            begin
                stat_next = ST_INVALID;
            end
            else if (sts.count_full)
            begin
                stat_next = ST_FULL;
            end
            else
            begin
                entry_count_next = entry_count_reg + CNT_W'(1);
            end
        end
        if (cmd.walk_en)
        begin
            if (!in_window)
            begin
                pin_state_next = pin_state_reg & ~pin_mask;
                set_night      = 1'b1;
            end
            else if (e_night)
            begin
                pin_state_next = pin_state_reg | pin_mask;
                set_start      = 1'b1;
                clr_night      = 1'b1;
            end
            else if (elapsed >= 32'(PERIOD_US))
            begin
                if (e_duty != 7'd0)
                begin
                    pin_state_next = pin_state_reg | pin_mask;
                end
                set_start = 1'b1;
            end
            else if (elapsed >= 32'(duty_thr))
            begin
                if (e_duty != 7'(DUTY_LIMIT))
                begin
                    pin_state_next = pin_state_reg & ~pin_mask;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            pin_state_reg   <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            pin_state_reg   <= pin_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
        if (cmd.load)
        begin
            pin_in_reg  <= pin_number;
            duty_in_reg <= duty_percent;
            wstart_reg  <= window_start;
            wend_reg    <= window_end;
            tod_reg     <= time_of_day;
            now_reg     <= now_us;
        end
        if (cfg_store)
        begin
            entry_pin_reg[wr_idx]   <= pin_in_reg[4:0];
            entry_duty_reg[wr_idx]  <= duty_in_reg[6:0];
            entry_open_reg[wr_idx]  <= wstart_reg[11:0];
            entry_close_reg[wr_idx] <= wend_reg[11:0];
            entry_night_reg[wr_idx] <= 1'b1;
        end
        if (set_night)
        begin
            entry_night_reg[cmd.walk_idx] <= 1'b1;
        end
        if (clr_night)
        begin
            entry_night_reg[cmd.walk_idx] <= 1'b0;
        end
        if (set_start)
        begin
            entry_start_reg[cmd.walk_idx] <= now_reg;
        end
        if (cmd.out_load)
        begin
            status_reg     <= stat_reg;
            pin_levels_reg <= pin_state_reg;
        end
    end

    assign status     = status_reg;
    assign pin_levels = pin_levels_reg;

endmodule

// ===== hw/rtl/smpwm_ctrl.sv =====
// Controller of the scheduled multichannel PWM block: item sequencing, entry
// walk counter and result valid. Depends on smpwm_pkg.
module smpwm_ctrl
    import smpwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       operation,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output smpwm_cmd_t cmd,
    input  smpwm_sts_t sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CFG  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             accept;
    logic             out_free;
    logic             last_entry;

    assign accept     = req_valid && (state_reg == S_IDLE);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == sts.entry_count);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.load     = 1'b0;
        cmd.cfg_en   = 1'b0;
        cmd.walk_en  = 1'b0;
        cmd.walk_idx = idx_reg;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    if (!operation)
                    begin
                        state_next = S_CFG;
                    end
                    else if (sts.entry_count == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_CFG:
            begin
                cmd.cfg_en = 1'b1;
                state_next = S_DONE;
            end
            S_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (last_entry)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                // The result waits here until the output register is free.
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== hw/rtl/scheduled_multichannel_pwm.sv =====
// Top level of the scheduled multichannel PWM block.
// Joins smpwm_ctrl and smpwm_dp; depends on smpwm_pkg and the defines header.
//
// Usage. Items enter on the req channel (req_valid, req_stall); each gives one
// result on the rsp channel (rsp_valid, rsp_stall) holding status and the 21
// pin levels after the item. An item is taken when valid is high and stall low.
// A configure item (operation 0) checks and appends one entry to an eight-entry
// table; a tick item (operation 1) walks the stored entries one per cycle and
// updates the pins, later entries winning on a shared pin.
// Steps: a configure item passes a check-and-store step and then a final step that
// loads the output register; a tick item walks each stored entry in turn through
// the single evaluation unit and then takes the same final step (a tick on an
// empty table goes straight to it).
// The result sits in an output register, so the next item is taken while the
// previous result is still stalled; a finished item waits in its final step
// until that register frees up, and req_stall stays high meanwhile.
// Reset clears the entry count, the pin state (all pins low) and the result valid;
// the table itself needs no clearing pass.
`include "scheduled_multichannel_pwm_defines.svh"
module scheduled_multichannel_pwm
    import smpwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic                 operation,
    input  logic [7:0]           pin_number,
    input  logic [7:0]           duty_percent,
    input  logic [15:0]          window_start,
    input  logic [15:0]          window_end,
    input  logic [15:0]          time_of_day,
    input  logic [31:0]          now_us,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [1:0]           status,
    output logic [PIN_COUNT-1:0] pin_levels
);

    smpwm_cmd_t cmd;
    smpwm_sts_t sts;

    smpwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    smpwm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .pin_number   (pin_number),
        .duty_percent (duty_percent),
        .window_start (window_start),
        .window_end   (window_end),
        .time_of_day  (time_of_day),
        .now_us       (now_us),
        .status       (status),
        .pin_levels   (pin_levels)
    );

    // An accepted item always keeps the input busy for at least the next cycle.
    `SMPWM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)
    // The walk never reaches past the stored entries.
    `SMPWM_ASSERT_NOW(a_walk_in_range, clk, rst_n, cmd.walk_en, CNT_W'(cmd.walk_idx) < sts.entry_count)
    // A configure on a full table leaves the count alone.
    `SMPWM_ASSERT_NEXT(a_full_holds, clk, rst_n, cmd.cfg_en && sts.count_full, $stable(sts.entry_count))
    // A result is loaded only while the output register is free.
    `SMPWM_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load, !rsp_valid || !rsp_stall)

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for scheduled_multichannel_pwm: predicts the status
// and the pin levels for every item and checks each result in order.
// Depends on smpwm_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
    import smpwm_pkg::*;

    localparam logic OP_CONFIG = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam int   RUN_LIMIT_NS = 5_000_000;
    localparam int   HOLD_CYCLES  = 90;

    typedef struct {
        logic [1:0]           status;
        logic [PIN_COUNT-1:0] pins;
    } pin_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic                 operation = OP_CONFIG;
    logic [7:0]           pin_number = '0;
    logic [7:0]           duty_percent = '0;
    logic [15:0]          window_start = '0;
    logic [15:0]          window_end = '0;
    logic [15:0]          time_of_day = '0;
    logic [31:0]          now_us = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [1:0]           status;
    logic [PIN_COUNT-1:0] pin_levels;

    // Predicted channel table and pin state.
    logic [4:0]           chan_pin [MAX_ENTRIES];
    logic [6:0]           chan_duty [MAX_ENTRIES];
    logic [11:0]          chan_open [MAX_ENTRIES];
    logic [11:0]          chan_close [MAX_ENTRIES];
    logic                 chan_night [MAX_ENTRIES];
    logic [31:0]          chan_start [MAX_ENTRIES];
    int                   chan_count = 0;
    logic [PIN_COUNT-1:0] pin_model = '0;

    pin_report_t pin_report_q[$];
    pin_report_t head_report;
    int          error_count = 0;

    // Traffic controls shared between the tests, the send task and the stall process.
    bit          send_gaps_off = 1'b0;
    bit          stall_off = 1'b0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;

    // Running time base for the random ticks.
    int          tick_tod = 0;
    logic [31:0] tick_now = 32'hFFFF_0000;

    scheduled_multichannel_pwm dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .pin_number   (pin_number),
        .duty_percent (duty_percent),
        .window_start (window_start),
        .window_end   (window_end),
        .time_of_day  (time_of_day),
        .now_us       (now_us),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .pin_levels   (pin_levels)
    );

    always #6 clk = ~clk;

    // Applies one accepted item to the predicted state and returns its result.
    function automatic pin_report_t compute_pin_report(
        logic op, logic [7:0] pin, logic [7:0] duty,
        logic [15:0] ws, logic [15:0] we, logic [15:0] tod, logic [31:0] now);
        pin_report_t rpt;
        logic [31:0] elapsed;
        rpt.status = ST_OK;
        if (op == OP_CONFIG)
        begin
            if (pin > PIN_LIMIT || duty > DUTY_LIMIT || ws > TIME_LIMIT ||
                we > TIME_LIMIT || we <= ws)
                rpt.status = ST_INVALID;
            else if (chan_count >= MAX_ENTRIES)
                rpt.status = ST_FULL;
            else
            begin
                chan_pin[chan_count]   = pin[4:0];
                chan_duty[chan_count]  = duty[6:0];
                chan_open[chan_count]  = ws[11:0];
                chan_close[chan_count] = we[11:0];
                chan_night[chan_count] = 1'b1;
                chan_count++;
            end
        end
        else
        begin
            for (int k = 0; k < chan_count; k++)
            begin
                if (tod < chan_open[k] || tod >= chan_close[k])
                begin
                    pin_model[chan_pin[k]] = 1'b0;
                    chan_night[k] = 1'b1;
                end
                else if (chan_night[k])
                begin
                    pin_model[chan_pin[k]] = 1'b1;
                    chan_start[k] = now;
                    chan_night[k] = 1'b0;
                end
                else
                begin
                    elapsed = now - chan_start[k];
                    if (elapsed >= PERIOD_US)
                    begin
                        if (chan_duty[k] != 0)
                            pin_model[chan_pin[k]] = 1'b1;
                        chan_start[k] = now;
                    end
                    else if (elapsed >= 32'(chan_duty[k]) * DUTY_STEP)
                    begin
                        if (chan_duty[k] != DUTY_LIMIT)
                            pin_model[chan_pin[k]] = 1'b0;
                    end
                end
            end
        end
        rpt.pins = pin_model;
        return rpt;
    endfunction

    // Offers one item, holds it until it is taken, and records its result.
    task automatic send_item(logic op, logic [7:0] pin, logic [7:0] duty,
                             logic [15:0] ws, logic [15:0] we,
                             logic [15:0] tod, logic [31:0] now);
        while (!send_gaps_off && $urandom_range(99) < 26)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        operation    <= op;
        pin_number   <= pin;
        duty_percent <= duty;
        window_start <= ws;
        window_end   <= we;
        time_of_day  <= tod;
        now_us       <= now;
        do
            @(posedge clk);
        while (req_stall);
        pin_report_q.push_back(compute_pin_report(op, pin, duty, ws, we, tod, now));
    endtask

    // The fields that an item ignores carry random values.
    task automatic send_config(logic [7:0] pin, logic [7:0] duty,
                               logic [15:0] ws, logic [15:0] we);
        send_item(OP_CONFIG, pin, duty, ws, we, 16'($urandom_range(65535)), $urandom);
    endtask

    task automatic send_tick(logic [15:0] tod, logic [31:0] now);
        send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)), tod, now);
    endtask

    task automatic send_random_item();
        int          roll;
        logic [15:0] ws;
        logic [15:0] tod;
        logic [7:0]  duty;
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            ws = 16'($urandom_range(TIME_LIMIT - 1));
            case ($urandom_range(3))
                0:       duty = 8'd0;
                1:       duty = 8'(DUTY_LIMIT);
                default: duty = 8'($urandom_range(DUTY_LIMIT));
            endcase
            send_config(8'($urandom_range(PIN_LIMIT)), duty, ws,
                        16'($urandom_range(TIME_LIMIT, ws + 1)));
        end
        else if (roll < 12)
        begin
            send_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                        16'($urandom_range(1) ? $urandom_range(65535)
                                              : $urandom_range(2401)),
                        16'($urandom_range(1) ? $urandom_range(65535)
                                              : $urandom_range(2401)));
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                tick_tod = (tick_tod + $urandom_range(40)) % (TIME_LIMIT + 1);
                tod = 16'(tick_tod);
            end
            else if (roll < 92)
                tod = 16'($urandom_range(TIME_LIMIT));
            else
                tod = 16'($urandom_range(65535));
            roll = $urandom_range(9);
            if (roll < 6)
                tick_now = tick_now + $urandom_range(4000);
            else if (roll < 9)
                tick_now = tick_now + $urandom_range(12000, 4000);
            else
                tick_now = $urandom;
            send_tick(tod, tick_now);
        end
    endtask

    task automatic test_directed();
        logic [31:0] base;
        base = 32'hFFFF_F000;
        send_tick(16'd1200, 32'd0);
        // Rejected entries: each field beyond its limit, and empty windows.
        send_config(8'd21, 8'd50, 16'd100, 16'd200);
        send_config(8'd255, 8'd255, 16'd65535, 16'd65535);
        send_config(8'd3, 8'd101, 16'd100, 16'd200);
        send_config(8'd3, 8'd50, 16'd2401, 16'd2402);
        send_config(8'd3, 8'd50, 16'd100, 16'd2401);
        send_config(8'd3, 8'd50, 16'd500, 16'd500);
        send_config(8'd3, 8'd50, 16'd600, 16'd500);
        // Accepted entries, including zero and full duty and a shared pin.
        send_config(8'd0, 8'd0, 16'd0, 16'd2400);
        send_config(8'd20, 8'd100, 16'd800, 16'd1800);
        send_config(8'd5, 8'd50, 16'd600, 16'd2000);
        send_config(8'd5, 8'd25, 16'd1000, 16'd1100);
        send_config(8'd7, 8'd100, 16'd2399, 16'd2400);
        // Ticks across duty thresholds, a period and the counter wrap.
        send_tick(16'd700, base);
        send_tick(16'd1050, base + 32'd1000);
        send_tick(16'd1060, base + 32'd3000);
        send_tick(16'd1070, base + 32'd6000);
        send_tick(16'd1080, base + 32'd11500);
        send_tick(16'd1150, base + 32'd14000);
        send_tick(16'd2399, base + 32'd15000);
        send_tick(16'd2400, base + 32'd16000);
        send_tick(16'd65535, 32'd0);
        send_tick(16'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_no_idle();
        send_gaps_off = 1'b1;
        stall_off = 1'b1;
        repeat (60) send_random_item();
        send_gaps_off = 1'b0;
        stall_off = 1'b0;
    endtask

    task automatic test_backpressure();
        send_gaps_off = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_random_item();
        send_gaps_off = 1'b0;
    endtask

    task automatic test_random();
        repeat (560) send_random_item();
    endtask

    // Receiver stall: random, quiet, or one long hold-off counted here.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_off)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < 26);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pin_report_q.size() == 0)
            begin
                $display("%0t: result with none expected: status %0d pins %h",
                         $time, status, pin_levels);
                error_count++;
            end
            else
            begin
                head_report = pin_report_q.pop_front();
                if (status !== head_report.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, head_report.status, status);
                    error_count++;
                end
                if (pin_levels !== head_report.pins)
                begin
                    $display("%0t: pin_levels mismatch: expected %h actual %h",
                             $time, head_report.pins, pin_levels);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_no_idle();
        test_backpressure();
        test_random();
        req_valid <= 1'b0;
        for (int i = 0; i < 2000 && pin_report_q.size() != 0; i++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pin_report_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, pin_report_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
